// ===== rtl/ssi_pkg.sv =====
package ssi_pkg;

    // default table depth
    localparam int CAPACITY_DEF = 16;

    // field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LIST   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // list sequencer states
    typedef enum logic
    {
        SEQ_IDLE,
        SEQ_LIST
    } seq_state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed
    {
        logic ins;   // commit an insert of the broadcast key
        logic rot;   // rotate valid entries one place toward cell 0
    } ssi_ctrl_t;

endpackage

// ===== rtl/ssi_cell.sv =====
module ssi_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssi_pkg::ssi_ctrl_t                   ctrl,
    input  logic signed [ssi_pkg::VALUE_W-1:0]   key,
    input  logic                                 prev_take,
    input  logic                                 prev_valid,
    input  logic signed [ssi_pkg::VALUE_W-1:0]   prev_value,
    input  logic                                 next_valid,
    input  logic signed [ssi_pkg::VALUE_W-1:0]   next_value,
    input  logic signed [ssi_pkg::VALUE_W-1:0]   head_value,
    output logic                                 take,
    output logic                                 eq,
    output logic                                 valid,
    output logic signed [ssi_pkg::VALUE_W-1:0]   value
);
    import ssi_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [VALUE_W-1:0]  value_reg;
    logic signed [VALUE_W-1:0]  value_next;

    // key belongs at or below this cell when the cell is empty or larger
    assign take  = !valid_reg || (value_reg > key);
    assign eq    = valid_reg && (value_reg == key);
    assign valid = valid_reg;
    assign value = value_reg;

    // next entry: shift up on insert, rotate down on list
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            valid_next = valid_reg | prev_valid;
            if (prev_take)
            begin
                value_next = prev_value;
            end
            else if (take)
            begin
                value_next = key;
            end
        end
        else if (ctrl.rot && valid_reg)
        begin
            value_next = next_valid ? next_value : head_value;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/sorted_set_insert_core.sv =====
// channel   | signals                                          | beat taken when
// ----------+--------------------------------------------------+----------------------
// command   | start, op, new_value / busy                      | start && !busy
// result    | result_valid, status, entry_value, entry_count,  | result_valid (one cycle)
//           | last                                             |
//
// in an insert all cells compare against the broadcast key at
// once and the larger entries shift up one cell; its result shows the next cycle
// a list leaves idle on its accept cycle, then rotates the cell row past cell 0 once
// per stored entry; busy is high for the rotation cycles, and the first beat passes the
// state register and then the result register; an empty list answers without busy
// reset clears the occupancy flags and count; stored values need no clearing
// the receiver cannot stall: every result is on the ports for exactly one cycle
module sorted_set_insert_core
#(
    parameter int CAPACITY = ssi_pkg::CAPACITY_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 op,
    input  logic signed [ssi_pkg::VALUE_W-1:0]   new_value,
    output logic                                 busy,
    output logic                                 result_valid,
    output logic [ssi_pkg::STATUS_W-1:0]         status,
    output logic signed [ssi_pkg::VALUE_W-1:0]   entry_value,
    output logic [ssi_pkg::COUNT_W-1:0]          entry_count,
    output logic                                 last
);
    import ssi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // cell row wiring
    logic [CAPACITY-1:0]                take_vec;
    logic [CAPACITY-1:0]                eq_vec;
    logic [CAPACITY-1:0]                valid_vec;
    logic signed [VALUE_W-1:0]          value_vec [CAPACITY];
    ssi_ctrl_t                          ctrl;

    // control state
    seq_state_t                         state_reg;
    seq_state_t                         state_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [CW-1:0]                      idx_reg;
    logic [CW-1:0]                      idx_next;

    // result register
    logic                               rvalid_reg;
    logic                               rvalid_next;
    logic [STATUS_W-1:0]                rstatus_reg;
    logic [STATUS_W-1:0]                rstatus_next;
    logic signed [VALUE_W-1:0]          rvalue_reg;
    logic signed [VALUE_W-1:0]          rvalue_next;
    logic [CW-1:0]                      rcount_reg;
    logic [CW-1:0]                      rcount_next;
    logic                               rlast_reg;
    logic                               rlast_next;

    logic                               accept;
    logic                               dup;
    logic                               full;
    logic                               list_end;

    assign accept   = start && !busy;
    assign dup      = |eq_vec;
    assign full     = valid_vec[CAPACITY-1];
    assign list_end = (CW'(idx_reg + 1'b1) == count_reg);

    // row of cells, entry 0 holds the smallest value
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                       p_take;
        logic                       p_valid;
        logic signed [VALUE_W-1:0]  p_value;
        logic                       n_valid;
        logic signed [VALUE_W-1:0]  n_value;

        if (i == 0)
        begin : g_first
            assign p_take  = 1'b0;
            assign p_valid = 1'b1;
            assign p_value = new_value;
        end
        else
        begin : g_mid
            assign p_take  = take_vec[i-1];
            assign p_valid = valid_vec[i-1];
            assign p_value = value_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_top
            assign n_valid = 1'b0;
            assign n_value = value_vec[0];
        end
        else
        begin : g_low
            assign n_valid = valid_vec[i+1];
            assign n_value = value_vec[i+1];
        end

        ssi_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (new_value),
            .prev_take  (p_take),
            .prev_valid (p_valid),
            .prev_value (p_value),
            .next_valid (n_valid),
            .next_value (n_value),
            .head_value (value_vec[0]),
            .take       (take_vec[i]),
            .eq         (eq_vec[i]),
            .valid      (valid_vec[i]),
            .value      (value_vec[i])
        );
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept && (op == OP_LIST) && (count_reg != '0))
                begin
                    state_next = SEQ_LIST;
                end
            end
            SEQ_LIST:
            begin
                if (list_end)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // sequencer outputs, cell commands and result beat
    always_comb
    begin
        busy         = 1'b0;
        ctrl         = '0;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rvalid_next  = 1'b0;
        rstatus_next = rstatus_reg;
        rvalue_next  = rvalue_reg;
        rcount_next  = rcount_reg;
        rlast_next   = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    rvalid_next = 1'b1;
                    rlast_next  = 1'b1;
                    rcount_next = count_reg;
                    rvalue_next = new_value;
                    if (op == OP_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            rstatus_next = ST_EMPTY;
                            rvalue_next  = '0;
                        end
                        else
                        begin
                            // first listed beat comes from the run state
                            rvalid_next = 1'b0;
                            rlast_next  = 1'b0;
                        end
                    end
                    else if (dup)
                    begin
                        rstatus_next = ST_DUPLICATE;
                    end
                    else if (full)
                    begin
                        rstatus_next = ST_FULL;
                    end
                    else
                    begin
                        rstatus_next = ST_INSERTED;
                        ctrl.ins     = 1'b1;
                        count_next   = CW'(count_reg + 1'b1);
                        rcount_next  = count_next;
                    end
                end
            end
            SEQ_LIST:
            begin
                busy         = 1'b1;
                ctrl.rot     = 1'b1;
                idx_next     = CW'(idx_reg + 1'b1);
                rvalid_next  = 1'b1;
                rstatus_next = ST_LISTED;
                rvalue_next  = value_vec[0];
                rcount_next  = count_reg;
                rlast_next   = list_end;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
            rlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rstatus_reg <= rstatus_next;
        rvalue_reg  <= rvalue_next;
        rcount_reg  <= rcount_next;
    end

    assign result_valid = rvalid_reg;
    assign status       = rstatus_reg;
    assign entry_value  = rvalue_reg;
    assign entry_count  = COUNT_W'(rcount_reg);
    assign last         = rlast_reg;

endmodule

// ===== rtl/ssi_checker.sv =====
module ssi_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 op,
    input  logic                                 busy,
    input  logic                                 result_valid,
    input  logic [ssi_pkg::STATUS_W-1:0]         status,
    input  logic                                 last
);
    import ssi_pkg::*;

    // every accepted beat yields a result or starts a listing in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_valid || busy))
        else $error("accepted command gave no result beat");

    // an insert answers with a single final beat
    a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_INSERT)) |=> (last && (status != ST_LISTED)))
        else $error("insert result is not a single final beat");

    // a listing in progress keeps producing beats
    a_busy_beat: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (result_valid && (status == ST_LISTED)))
        else $error("listing cycle produced no listed beat");

    // status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_INSERTED || status == ST_DUPLICATE ||
                          status == ST_FULL || status == ST_LISTED ||
                          status == ST_EMPTY))
        else $error("result status out of range");

    // a non-final listed beat keeps the block busy
    a_list_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("listing stopped before its final beat");

endmodule

bind sorted_set_insert_core ssi_checker u_ssi_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .op           (op),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .last         (last)
);

// ===== dv/sorted_set_checker.sv =====
module sorted_set_checker
    import ssi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        op,
    input  logic signed [VALUE_W-1:0]   new_value,
    input  logic                        busy,
    input  logic                        result_valid,
    input  logic [STATUS_W-1:0]         status,
    input  logic signed [VALUE_W-1:0]   entry_value,
    input  logic [COUNT_W-1:0]          entry_count,
    input  logic                        last,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one expected result beat
    typedef struct packed
    {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } result_beat_t;

    result_beat_t              expected_beats[$];
    logic signed [VALUE_W-1:0] set_values[CAPACITY_DEF];
    int                        set_size;
    int                        mismatches = 0;

    assign fail_count = mismatches;

    function automatic void push_beat(input logic [STATUS_W-1:0] st,
                                      input logic signed [VALUE_W-1:0] v,
                                      input int n,
                                      input logic lst);
        result_beat_t b;
        b.status = st;
        b.value  = v;
        b.count  = n[COUNT_W-1:0];
        b.last   = lst;
        expected_beats.push_back(b);
    endfunction

    // sorted set model: works out the beats one command causes
    function automatic void predict_command(input logic o, input logic signed [VALUE_W-1:0] v);
        int pos;
        if (o == OP_LIST)
        begin
            if (set_size == 0)
                push_beat(ST_EMPTY, '0, 0, 1'b1);
            else
                for (int i = 0; i < set_size; i++)
                    push_beat(ST_LISTED, set_values[i], set_size, i == set_size - 1);
        end
        else
        begin
            // first entry not below the new value, signed order
            pos = 0;
            while (pos < set_size && set_values[pos] < v)
                pos++;
            // duplicate check wins over full
            if (pos < set_size && set_values[pos] == v)
                push_beat(ST_DUPLICATE, v, set_size, 1'b1);
            else if (set_size >= CAPACITY_DEF)
                push_beat(ST_FULL, v, set_size, 1'b1);
            else
            begin
                for (int i = set_size; i > pos; i--)
                    set_values[i] = set_values[i-1];
                set_values[pos] = v;
                set_size++;
                push_beat(ST_INSERTED, v, set_size, 1'b1);
            end
        end
    endfunction

    function automatic void flag_field(input string field,
                                       input logic signed [VALUE_W-1:0] exp_v,
                                       input logic signed [VALUE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endfunction

    // compare one result beat with the oldest expectation
    function automatic void check_beat();
        result_beat_t exp_b;
        if (expected_beats.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result beat, expected none, actual status %0d value %0d",
                     $time, status, entry_value);
        end
        else
        begin
            exp_b = expected_beats.pop_front();
            flag_field("status", exp_b.status, status);
            flag_field("entry_value", exp_b.value, entry_value);
            flag_field("entry_count", exp_b.count, entry_count);
            flag_field("last", exp_b.last, last);
        end
    endfunction

    // watch the command and result channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            set_size = 0;
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_command(op, new_value);
            if (result_valid)
                check_beat();
            pending <= expected_beats.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssi_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 150;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       op;
    logic signed [VALUE_W-1:0]  new_value;
    logic                       busy;
    logic                       result_valid;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [COUNT_W-1:0]         entry_count;
    logic                       last;
    int                         fail_count;
    int                         pending;

    int                         idle_pct;
    int                         cycle_count = 0;
    logic signed [VALUE_W-1:0]  sent_values[$];
    bit                         distinct_values[int];

    sorted_set_insert_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .new_value    (new_value),
        .busy         (busy),
        .result_valid (result_valid),
        .status       (status),
        .entry_value  (entry_value),
        .entry_count  (entry_count),
        .last         (last)
    );

    sorted_set_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .new_value    (new_value),
        .busy         (busy),
        .result_valid (result_valid),
        .status       (status),
        .entry_value  (entry_value),
        .entry_count  (entry_count),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one command beat, with random idle cycles ahead of it
    task automatic send_cmd(input logic o, input logic signed [VALUE_W-1:0] v);
        logic free;
        while ($urandom_range(99) < idle_pct)
        begin
            start     <= 1'b0;
            op        <= 1'($urandom_range(1));
            new_value <= $urandom;
            @(posedge clk);
        end
        start     <= 1'b1;
        op        <= o;
        new_value <= v;
        // hold the beat until an edge finds the block free
        free = 1'b0;
        while (!free)
        begin
            @(negedge clk);
            free = !busy;
            @(posedge clk);
        end
        if (o == OP_INSERT)
        begin
            sent_values.push_back(v);
            distinct_values[int'(v)] = 1'b1;
        end
    endtask

    // random insert value: often a sent one, some extremes, small values near zero, else random
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40 && sent_values.size() > 0)
            return sent_values[$urandom_range(sent_values.size() - 1)];
        else if (sel < 45)
            return {1'b0, {(VALUE_W-1){1'b1}}};
        else if (sel < 50)
            return {1'b1, {(VALUE_W-1){1'b0}}};
        else if (sel < 65)
            return $signed($urandom_range(16)) - 8;
        return $urandom;
    endfunction

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_INSERT;
        new_value = '0;
        idle_pct  = 21;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, extremes, duplicate, partial list
        send_cmd(OP_LIST, $urandom);
        send_cmd(OP_INSERT, {1'b0, {(VALUE_W-1){1'b1}}});
        send_cmd(OP_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
        send_cmd(OP_INSERT, 0);
        send_cmd(OP_INSERT, -1);
        send_cmd(OP_INSERT, 1);
        send_cmd(OP_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
        send_cmd(OP_LIST, 0);
        send_cmd(OP_INSERT, 32'h5555_5555);
        send_cmd(OP_INSERT, 32'hAAAA_AAAA);

        // directed: fill the table, then duplicate and overflow on a full table
        while (distinct_values.num() < CAPACITY_DEF)
            send_cmd(OP_INSERT, $urandom);
        send_cmd(OP_LIST, -1);
        send_cmd(OP_INSERT, 0);
        send_cmd(OP_INSERT, 2);
        send_cmd(OP_LIST, 0);

        // random: three idle profiles on the command side
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 54 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 20)
                    send_cmd(OP_LIST, $urandom);
                else
                    send_cmd(OP_INSERT, pick_value());
            end
        end
        start <= 1'b0;

        // drain outstanding beats, then watch for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
